// ----- rtl/avfa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// avfa_pkg
// Shared types and constants of the active vertex FIFO and address stage.
// ----------------------------------------------------------------------------
package avfa_pkg;

    localparam int VID_W  = 24;
    localparam int ADDR_W = 20;
    localparam int ITER_W = 16;

    localparam int DEF_NUM_CORES      = 16;
    localparam int DEF_FIFO_DEPTH     = 16;
    localparam int DEF_END_WAIT       = 8;
    localparam int DEF_VERTEX_ID_BITS = 24;

    typedef struct packed {
        logic              sync_clear;
        logic [VID_W-1:0]  in_vertex_id;
        logic              in_vertex_valid;
        logic              in_iter_end;
        logic              in_iter_end_valid;
        logic [ITER_W-1:0] in_iter_id;
        logic              downstream_full;
    } in_item_t;

    typedef struct packed {
        logic              fifo_full;
        logic [VID_W-1:0]  out_vertex_id;
        logic [ADDR_W-1:0] offset_address;
        logic [ADDR_W-1:0] value_address;
        logic              out_vertex_valid;
        logic              out_iter_end;
        logic              out_iter_end_valid;
        logic [ITER_W-1:0] out_iter_id;
    } out_item_t;

    // per-cell control: load the arriving entry, or take the neighbor's entry
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/avfa_stream_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// avfa_stream_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface avfa_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ----- rtl/avfa_recip_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// avfa_recip_div
// Vertex id divided by the core count, by multiplication with a rounded-up
// reciprocal. Exact for every id below 2**ID_W.
// ----------------------------------------------------------------------------
module avfa_recip_div #(
    parameter int NUM_CORES = 16,
    parameter int ID_W      = 24
) (
    input  wire logic [ID_W-1:0]            id,
    output logic      [avfa_pkg::ADDR_W-1:0] quot
);
    import avfa_pkg::*;

    localparam int SHIFT  = ID_W + $clog2(NUM_CORES);
    localparam int PROD_W = 2 * ID_W + 1 + ADDR_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(NUM_CORES) - 64'd1) / 64'(NUM_CORES);
    localparam logic [ID_W:0] RECIP = RECIP_FULL[ID_W:0];

    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] shifted;

    assign prod    = PROD_W'(id) * PROD_W'(RECIP);
    assign shifted = prod >> SHIFT;
    assign quot    = shifted[ADDR_W-1:0];

endmodule
`default_nettype wire

// ----- rtl/avfa_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// avfa_cell
// One FIFO slot: holds an id and its address, loads a new entry or takes
// the entry of the next cell toward the tail when the head pops.
// ----------------------------------------------------------------------------
module avfa_cell #(
    parameter int ID_W = 24
) (
    input  wire logic                        clk,
    input  wire avfa_pkg::cell_ctrl_t        ctrl,
    input  wire logic [ID_W-1:0]             new_id,
    input  wire logic [avfa_pkg::ADDR_W-1:0] new_addr,
    input  wire logic [ID_W-1:0]             nbr_id,
    input  wire logic [avfa_pkg::ADDR_W-1:0] nbr_addr,
    output logic      [ID_W-1:0]             id,
    output logic      [avfa_pkg::ADDR_W-1:0] addr
);
    import avfa_pkg::*;

    logic [ID_W-1:0]   id_reg;
    logic [ADDR_W-1:0] addr_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            id_reg   <= new_id;
            addr_reg <= new_addr;
        end
        else if (ctrl.shift)
        begin
            id_reg   <= nbr_id;
            addr_reg <= nbr_addr;
        end
    end

    assign id   = id_reg;
    assign addr = addr_reg;

endmodule
`default_nettype wire

// ----- rtl/active_vertex_fifo_address_stage.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// active_vertex_fifo_address_stage
// Active vertex FIFO with offset/value address generation and delayed
// iteration-end forwarding for one core.
//
//   channel  dir  payload     one transaction is
//   in_ch    in   in_item_t   one clock step of the upstream stage
//   out_ch   out  out_item_t  the result of that step
//
// One transaction in per cycle unless stalled; its result sits in the output
// register the next cycle. The FIFO is a chain of cells shifting toward the
// head on pop; the address divide happens on the push path, so the pop path
// is a read of the head cell. in_ch.ready drops only while a result waits and
// out_ch is stalled. Reset empties the FIFO and clears the end-wait counter.
// ----------------------------------------------------------------------------
module active_vertex_fifo_address_stage #(
    parameter int NUM_CORES      = avfa_pkg::DEF_NUM_CORES,
    parameter int FIFO_DEPTH     = avfa_pkg::DEF_FIFO_DEPTH,
    parameter int END_WAIT       = avfa_pkg::DEF_END_WAIT,
    parameter int VERTEX_ID_BITS = avfa_pkg::DEF_VERTEX_ID_BITS
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    avfa_stream_if.sink   in_ch,
    avfa_stream_if.source out_ch
);
    import avfa_pkg::*;

    localparam int ID_W   = (VERTEX_ID_BITS < VID_W) ? VERTEX_ID_BITS : VID_W;
    localparam int CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam int WAIT_W = (END_WAIT > 0) ? $clog2(END_WAIT + 1) : 1;

    in_item_t  item;
    out_item_t res_next;
    out_item_t out_reg;
    logic      out_valid_reg;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [WAIT_W-1:0] wait_reg;
    logic [WAIT_W-1:0] wait_next;

    logic accept;
    logic clear;
    logic was_empty;
    logic was_full;
    logic push;
    logic pop;
    logic end_cond;
    logic end_fire;

    logic [ID_W-1:0]   new_id;
    logic [ADDR_W-1:0] new_addr;
    logic [CNT_W-1:0]  tail;

    logic [ID_W-1:0]   cell_id   [FIFO_DEPTH];
    logic [ADDR_W-1:0] cell_addr [FIFO_DEPTH];
    cell_ctrl_t        cell_ctrl [FIFO_DEPTH];

    assign item      = in_ch.payload;
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept    = in_ch.valid && in_ch.ready;
    assign clear     = item.sync_clear;
    assign was_empty = (count_reg == '0);
    assign was_full  = (count_reg == CNT_W'(FIFO_DEPTH));
    assign push      = accept && !clear && item.in_vertex_valid && !was_full;
    assign pop       = accept && !clear && !item.downstream_full && !was_empty;
    // with a pop in the same step the tail slides down one cell
    assign tail      = pop ? (count_reg - CNT_W'(1)) : count_reg;
    assign new_id    = item.in_vertex_id[ID_W-1:0];

    avfa_recip_div #(
        .NUM_CORES (NUM_CORES),
        .ID_W      (ID_W)
    ) u_div (
        .id   (new_id),
        .quot (new_addr)
    );

    for (genvar i = 0; i < FIFO_DEPTH; i++)
    begin : g_cell
        logic [ID_W-1:0]   nbr_id;
        logic [ADDR_W-1:0] nbr_addr;

        if (i == FIFO_DEPTH - 1)
        begin : g_last
            assign nbr_id   = cell_id[i];
            assign nbr_addr = cell_addr[i];
        end
        else
        begin : g_mid
            assign nbr_id   = cell_id[i+1];
            assign nbr_addr = cell_addr[i+1];
        end

        assign cell_ctrl[i].load  = push && (tail == CNT_W'(i));
        assign cell_ctrl[i].shift = pop;

        avfa_cell #(
            .ID_W (ID_W)
        ) u_cell (
            .clk      (clk),
            .ctrl     (cell_ctrl[i]),
            .new_id   (new_id),
            .new_addr (new_addr),
            .nbr_id   (nbr_id),
            .nbr_addr (nbr_addr),
            .id       (cell_id[i]),
            .addr     (cell_addr[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (accept)
        begin
            if (clear)
                count_next = '0;
            else if (push && !pop)
                count_next = count_reg + CNT_W'(1);
            else if (pop && !push)
                count_next = count_reg - CNT_W'(1);
        end
    end

    assign end_cond = !clear && item.in_iter_end && item.in_iter_end_valid
                      && was_empty && !item.in_vertex_valid;
    assign end_fire = end_cond && (wait_reg >= WAIT_W'(END_WAIT));

    always_comb
    begin
        wait_next = wait_reg;
        if (accept)
        begin
            if (!end_cond)
                wait_next = '0;
            else if (!end_fire)
                wait_next = wait_reg + WAIT_W'(1);
        end
    end

    always_comb
    begin
        res_next.fifo_full          = (count_next == CNT_W'(FIFO_DEPTH));
        res_next.out_vertex_id      = pop ? VID_W'(cell_id[0]) : '0;
        res_next.offset_address     = pop ? cell_addr[0] : '0;
        res_next.value_address      = pop ? cell_addr[0] : '0;
        res_next.out_vertex_valid   = pop;
        res_next.out_iter_end       = end_fire;
        res_next.out_iter_end_valid = end_fire;
        res_next.out_iter_id        = item.in_iter_id;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            wait_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            wait_reg  <= wait_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= res_next;
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.payload = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("FIFO count above depth");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        accept && clear |=> count_reg == '0 && wait_reg == '0)
        else $error("clear did not empty the FIFO");

    a_wait_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wait_reg <= WAIT_W'(END_WAIT))
        else $error("end-wait counter above limit");

    a_end_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.out_iter_end |-> !out_reg.out_vertex_valid)
        else $error("iteration end forwarded together with a vertex");

endmodule
`default_nettype wire

// ----- verif/active_vertex_fifo_address_stage_tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// active_vertex_fifo_address_stage_tb
// Self-checking bench for the active vertex FIFO / address stage. A directed
// table covers the edge cases: extremes, clear, push while full, push into an
// empty FIFO, and the iteration-end hold-off. Random traffic follows, in
// fill, drain, end-wait and noise bursts. A cycle-level model of the stage
// predicts results the table leaves open; all are compared field by field, in order.
// ----------------------------------------------------------------------------
module active_vertex_fifo_address_stage_tb;

    import avfa_pkg::*;

    localparam int NUM_CORES      = DEF_NUM_CORES;
    localparam int FIFO_DEPTH     = DEF_FIFO_DEPTH;
    localparam int END_WAIT       = DEF_END_WAIT;
    localparam int VERTEX_ID_BITS = DEF_VERTEX_ID_BITS;
    localparam int IDX_W          = $clog2(FIFO_DEPTH);

    localparam int RANDOM_PER_PHASE = 425;
    localparam int NUM_PHASES       = 4;
    localparam int MAX_GAP          = 30;
    localparam int DRAIN_TAIL       = 10;
    localparam int CYCLE_LIMIT      = 400000;

    localparam int SRC_IDLE_PCT[NUM_PHASES]   = '{0, 62, 0, 21};
    localparam int SINK_STALL_PCT[NUM_PHASES] = '{0, 0, 62, 21};

    typedef enum int {
        BURST_FILL,
        BURST_DRAIN,
        BURST_END_WAIT,
        BURST_NOISE
    } burst_kind_t;

    typedef struct {
        in_item_t  stim;
        int        reps;
        bit        typed;
        out_item_t res;
    } dir_row_t;

    logic clk;
    logic rst_n;

    avfa_stream_if #(.payload_t(in_item_t))  in_if ();
    avfa_stream_if #(.payload_t(out_item_t)) out_if ();

    active_vertex_fifo_address_stage #(
        .NUM_CORES      (NUM_CORES),
        .FIFO_DEPTH     (FIFO_DEPTH),
        .END_WAIT       (END_WAIT),
        .VERTEX_ID_BITS (VERTEX_ID_BITS)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if),
        .out_ch (out_if)
    );

    // model state
    logic [VID_W-1:0] vertex_fifo [FIFO_DEPTH];
    int unsigned      fifo_count;
    int unsigned      fifo_head;
    int unsigned      end_hold_count;

    out_item_t pending_results [$];
    int        mismatches;
    int        items_sent;
    int        cycle_count;
    int        src_idle_pct;
    int        sink_stall_pct;

    // typed expectation riding along with the current transaction
    bit        cur_typed;
    out_item_t cur_res;

    out_item_t predicted;
    out_item_t observed;

    dir_row_t dir_rows [$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // one clock step of the stage
    function automatic out_item_t advance_stage(input in_item_t it);
        out_item_t        r;
        logic             was_empty;
        logic             was_full;
        logic [VID_W-1:0] head_id;
        logic [31:0]      quot;
        logic [IDX_W-1:0] slot;
        r = '0;
        was_empty = (fifo_count == 0);
        was_full  = (fifo_count >= FIFO_DEPTH);
        if (it.sync_clear)
        begin
            fifo_count = 0;
            fifo_head  = 0;
        end
        else
        begin
            if (it.in_vertex_valid && !was_full)
            begin
                slot = IDX_W'((fifo_head + fifo_count) % FIFO_DEPTH);
                vertex_fifo[slot] = it.in_vertex_id;
                fifo_count++;
            end
            if (!it.downstream_full && !was_empty)
            begin
                slot = IDX_W'(fifo_head);
                head_id = vertex_fifo[slot];
                quot = 32'(head_id) / NUM_CORES;
                r.out_vertex_id    = head_id;
                r.offset_address   = quot[ADDR_W-1:0];
                r.value_address    = quot[ADDR_W-1:0];
                r.out_vertex_valid = 1'b1;
                fifo_head = (fifo_head + 1) % FIFO_DEPTH;
                fifo_count--;
            end
        end
        if (!it.sync_clear && it.in_iter_end && it.in_iter_end_valid && was_empty &&
            !it.in_vertex_valid)
        begin
            if (end_hold_count >= END_WAIT)
            begin
                r.out_iter_end       = 1'b1;
                r.out_iter_end_valid = 1'b1;
            end
            else
            begin
                end_hold_count++;
            end
        end
        else
        begin
            end_hold_count = 0;
        end
        r.fifo_full   = (fifo_count >= FIFO_DEPTH);
        r.out_iter_id = it.in_iter_id;
        return r;
    endfunction

    function automatic in_item_t mk_in(input logic clr, input logic [VID_W-1:0] vid,
                                       input logic vv, input logic iend, input logic iendv,
                                       input logic [ITER_W-1:0] iter, input logic dfull);
        in_item_t it;
        it.sync_clear        = clr;
        it.in_vertex_id      = vid;
        it.in_vertex_valid   = vv;
        it.in_iter_end       = iend;
        it.in_iter_end_valid = iendv;
        it.in_iter_id        = iter;
        it.downstream_full   = dfull;
        return it;
    endfunction

    function automatic out_item_t mk_out(input logic full, input logic [VID_W-1:0] vid,
                                         input logic [ADDR_W-1:0] addr, input logic vv,
                                         input logic iend, input logic [ITER_W-1:0] iter);
        out_item_t r;
        r.fifo_full          = full;
        r.out_vertex_id      = vid;
        r.offset_address     = addr;
        r.value_address      = addr;
        r.out_vertex_valid   = vv;
        r.out_iter_end       = iend;
        r.out_iter_end_valid = iend;
        r.out_iter_id        = iter;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
        if (e !== a)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
            mismatches++;
        end
    endtask

    task automatic compare_result(input out_item_t e, input out_item_t a);
        check_field("fifo_full",          32'(e.fifo_full),          32'(a.fifo_full));
        check_field("out_vertex_id",      32'(e.out_vertex_id),      32'(a.out_vertex_id));
        check_field("offset_address",     32'(e.offset_address),     32'(a.offset_address));
        check_field("value_address",      32'(e.value_address),      32'(a.value_address));
        check_field("out_vertex_valid",   32'(e.out_vertex_valid),   32'(a.out_vertex_valid));
        check_field("out_iter_end",       32'(e.out_iter_end),       32'(a.out_iter_end));
        check_field("out_iter_end_valid", 32'(e.out_iter_end_valid), 32'(a.out_iter_end_valid));
        check_field("out_iter_id",        32'(e.out_iter_id),        32'(a.out_iter_id));
    endtask

    // both edges of the handshake are observed at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_if.valid && in_if.ready)
            begin
                predicted = advance_stage(in_if.payload);
                if (cur_typed)
                    predicted = cur_res;
                pending_results.push_back(predicted);
            end
            if (out_if.valid && out_if.ready)
            begin
                observed = out_if.payload;
                if (pending_results.size() == 0)
                begin
                    $error("result transaction with nothing outstanding");
                    mismatches++;
                end
                else
                begin
                    compare_result(pending_results.pop_front(), observed);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        out_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input in_item_t it, input bit typed, input out_item_t res);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct && gap < MAX_GAP)
            gap++;
        if (gap > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= it;
        cur_typed = typed;
        cur_res   = res;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    function automatic in_item_t random_base();
        in_item_t it;
        it = '0;
        it.in_vertex_id = VID_W'($urandom_range(0, (1 << VID_W) - 1));
        it.in_iter_id   = ITER_W'($urandom_range(0, (1 << ITER_W) - 1));
        return it;
    endfunction

    task automatic run_random(input int target);
        burst_kind_t kind;
        in_item_t    it;
        int          len;
        int          pick;
        int          i;
        while (items_sent < target)
        begin
            pick = $urandom_range(99);
            kind = (pick < 30) ? BURST_FILL :
                   (pick < 55) ? BURST_DRAIN :
                   (pick < 85) ? BURST_END_WAIT : BURST_NOISE;
            case (kind)
                BURST_FILL:
                begin
                    len = $urandom_range(4, 40);
                    for (i = 0; i < len; i++)
                    begin
                        it = random_base();
                        it.in_vertex_valid   = ($urandom_range(99) < 85);
                        it.downstream_full   = ($urandom_range(99) < 70);
                        it.in_iter_end       = 1'($urandom_range(1));
                        it.in_iter_end_valid = 1'($urandom_range(1));
                        it.sync_clear        = ($urandom_range(99) < 2);
                        send_item(it, 1'b0, '0);
                    end
                end
                BURST_DRAIN:
                begin
                    len = $urandom_range(4, 24);
                    for (i = 0; i < len; i++)
                    begin
                        it = random_base();
                        it.in_vertex_valid   = ($urandom_range(99) < 20);
                        it.downstream_full   = ($urandom_range(99) < 15);
                        it.in_iter_end       = 1'($urandom_range(1));
                        it.in_iter_end_valid = 1'($urandom_range(1));
                        it.sync_clear        = ($urandom_range(99) < 2);
                        send_item(it, 1'b0, '0);
                    end
                end
                BURST_END_WAIT:
                begin
                    // empty the FIFO first, then hold the end condition
                    for (i = 0; i <= FIFO_DEPTH; i++)
                    begin
                        it = random_base();
                        it.in_iter_end       = 1'($urandom_range(1));
                        it.in_iter_end_valid = 1'($urandom_range(1));
                        send_item(it, 1'b0, '0);
                    end
                    len = $urandom_range(0, 2 * END_WAIT + 4);
                    for (i = 0; i < len; i++)
                    begin
                        it = random_base();
                        it.in_iter_end       = ($urandom_range(99) >= 3);
                        it.in_iter_end_valid = ($urandom_range(99) >= 3);
                        it.in_vertex_valid   = ($urandom_range(99) < 4);
                        it.downstream_full   = 1'($urandom_range(1));
                        it.sync_clear        = ($urandom_range(99) < 2);
                        send_item(it, 1'b0, '0);
                    end
                end
                default:
                begin
                    len = $urandom_range(1, 10);
                    for (i = 0; i < len; i++)
                    begin
                        it = random_base();
                        it.in_vertex_valid   = 1'($urandom_range(1));
                        it.downstream_full   = 1'($urandom_range(1));
                        it.in_iter_end       = 1'($urandom_range(1));
                        it.in_iter_end_valid = 1'($urandom_range(1));
                        it.sync_clear        = ($urandom_range(99) < 10);
                        send_item(it, 1'b0, '0);
                    end
                end
            endcase
        end
    endtask

    initial
    begin
        int p;
        int k;
        int target;
        rst_n          = 1'b0;
        in_if.valid    = 1'b0;
        in_if.payload  = '0;
        out_if.ready   = 1'b0;
        mismatches     = 0;
        items_sent     = 0;
        cycle_count    = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        cur_typed      = 1'b0;
        cur_res        = '0;
        fifo_count     = 0;
        fifo_head      = 0;
        end_hold_count = 0;

        // idle, then extreme ids through push and pop
        dir_rows.push_back('{mk_in(1'b0, 24'h000000, 1'b0, 1'b0, 1'b0, 16'hFFFF, 1'b0),
                             1, 1'b1,
                             mk_out(1'b0, 24'h000000, 20'h00000, 1'b0, 1'b0, 16'hFFFF)});
        dir_rows.push_back('{mk_in(1'b0, 24'hFFFFFF, 1'b1, 1'b0, 1'b0, 16'h0000, 1'b1),
                             1, 1'b1,
                             mk_out(1'b0, 24'h000000, 20'h00000, 1'b0, 1'b0, 16'h0000)});
        dir_rows.push_back('{mk_in(1'b0, 24'h000000, 1'b1, 1'b0, 1'b0, 16'h8001, 1'b0),
                             1, 1'b1,
                             mk_out(1'b0, 24'hFFFFFF, 20'hFFFFF, 1'b1, 1'b0, 16'h8001)});
        dir_rows.push_back('{mk_in(1'b0, 24'h000000, 1'b0, 1'b0, 1'b0, 16'h0001, 1'b0),
                             1, 1'b1,
                             mk_out(1'b0, 24'h000000, 20'h00000, 1'b1, 1'b0, 16'h0001)});
        // push into empty FIFO cannot pop in the same cycle
        dir_rows.push_back('{mk_in(1'b0, 24'h123456, 1'b1, 1'b0, 1'b0, 16'h7FFF, 1'b0),
                             1, 1'b1,
                             mk_out(1'b0, 24'h000000, 20'h00000, 1'b0, 1'b0, 16'h7FFF)});
        // clear beats push, pop and end
        dir_rows.push_back('{mk_in(1'b1, 24'h654321, 1'b1, 1'b1, 1'b1, 16'h00FF, 1'b0),
                             1, 1'b1,
                             mk_out(1'b0, 24'h000000, 20'h00000, 1'b0, 1'b0, 16'h00FF)});
        dir_rows.push_back('{mk_in(1'b0, 24'h000000, 1'b0, 1'b0, 1'b0, 16'hFF00, 1'b0),
                             1, 1'b1,
                             mk_out(1'b0, 24'h000000, 20'h00000, 1'b0, 1'b0, 16'hFF00)});
        // fill to full, then push while full (with and without a pop)
        dir_rows.push_back('{mk_in(1'b0, 24'hABCDE0, 1'b1, 1'b0, 1'b0, 16'h0002, 1'b1),
                             FIFO_DEPTH, 1'b0, '0});
        dir_rows.push_back('{mk_in(1'b0, 24'h00AAAA, 1'b1, 1'b0, 1'b0, 16'h0003, 1'b1),
                             1, 1'b1,
                             mk_out(1'b1, 24'h000000, 20'h00000, 1'b0, 1'b0, 16'h0003)});
        dir_rows.push_back('{mk_in(1'b0, 24'h00BBBB, 1'b1, 1'b0, 1'b0, 16'h0004, 1'b0),
                             1, 1'b1,
                             mk_out(1'b0, 24'hABCDE0, 20'hABCDE, 1'b1, 1'b0, 16'h0004)});
        dir_rows.push_back('{mk_in(1'b0, 24'h000000, 1'b0, 1'b0, 1'b0, 16'h0005, 1'b0),
                             FIFO_DEPTH, 1'b0, '0});
        // end condition held past the wait, then broken in each way
        dir_rows.push_back('{mk_in(1'b0, 24'h000000, 1'b0, 1'b1, 1'b1, 16'h0006, 1'b0),
                             END_WAIT + 4, 1'b0, '0});
        dir_rows.push_back('{mk_in(1'b0, 24'h000000, 1'b0, 1'b0, 1'b1, 16'h0007, 1'b0),
                             1, 1'b0, '0});
        dir_rows.push_back('{mk_in(1'b0, 24'h000000, 1'b0, 1'b1, 1'b0, 16'h0008, 1'b1),
                             3, 1'b0, '0});
        dir_rows.push_back('{mk_in(1'b0, 24'h000000, 1'b0, 1'b1, 1'b1, 16'h0009, 1'b1),
                             5, 1'b0, '0});
        dir_rows.push_back('{mk_in(1'b1, 24'h000000, 1'b0, 1'b1, 1'b1, 16'h000A, 1'b0),
                             1, 1'b0, '0});
        dir_rows.push_back('{mk_in(1'b0, 24'h000000, 1'b0, 1'b1, 1'b1, 16'h000B, 1'b0),
                             END_WAIT + 2, 1'b0, '0});
        dir_rows.push_back('{mk_in(1'b0, 24'h000010, 1'b1, 1'b1, 1'b1, 16'h000C, 1'b1),
                             1, 1'b0, '0});
        dir_rows.push_back('{mk_in(1'b0, 24'h000000, 1'b0, 1'b1, 1'b1, 16'h000D, 1'b0),
                             END_WAIT + 3, 1'b0, '0});
        // clear while full
        dir_rows.push_back('{mk_in(1'b0, 24'h0F0F0F, 1'b1, 1'b0, 1'b0, 16'h000E, 1'b1),
                             FIFO_DEPTH + 1, 1'b0, '0});
        dir_rows.push_back('{mk_in(1'b1, 24'hF0F0F0, 1'b1, 1'b0, 1'b0, 16'h000F, 1'b1),
                             1, 1'b1,
                             mk_out(1'b0, 24'h000000, 20'h00000, 1'b0, 1'b0, 16'h000F)});
        dir_rows.push_back('{mk_in(1'b0, 24'h000000, 1'b0, 1'b0, 1'b0, 16'h0010, 1'b0),
                             1, 1'b0, '0});

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        foreach (dir_rows[r])
            for (k = 0; k < dir_rows[r].reps; k++)
                send_item(dir_rows[r].stim, dir_rows[r].typed, dir_rows[r].res);

        target = items_sent;
        for (p = 0; p < NUM_PHASES; p++)
        begin
            src_idle_pct   = SRC_IDLE_PCT[p];
            sink_stall_pct = SINK_STALL_PCT[p];
            target += RANDOM_PER_PHASE;
            run_random(target);
        end

        in_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire

// ----- filelist.f -----
rtl/avfa_pkg.sv
rtl/avfa_stream_if.sv
rtl/avfa_recip_div.sv
rtl/avfa_cell.sv
rtl/active_vertex_fifo_address_stage.sv
verif/active_vertex_fifo_address_stage_tb.sv
